// File: hw/rtl/pdm_pkg.sv
package pdm_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_POINTS_DEF = 8;
	localparam int COORD_BITS_DEF = 16;

	// Fixed port widths.
	localparam int COORD_PORT_W = 16;
	localparam int IDX_PORT_W   = 3;
	localparam int DIST_W       = 17;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_ROW,
		ST_ROW_CAP,
		ST_RD_COL,
		ST_DIFF,
		ST_SQR,
		ST_SUM,
		ST_ROOT,
		ST_EMIT
	} state_t;

endpackage

// File: hw/rtl/pairwise_distance_matrix_3d.sv
// Pairwise Euclidean distance matrix of a small set of 3D points.
// A point word is taken at a rising edge where start is high and busy is low.
// Points are stored one after another; a word with last_point set closes the
// set, and the block then emits the N-by-N matrix of distances in row-major
// order, one result word per cycle of done, with row_index, col_index, the
// floor of the distance, last_result on the final entry and overflow when
// points beyond MAX_POINTS were dropped from this set.
// A point that does not close the set leaves the block idle and busy stays low.
// Each matrix entry passes through a read of the second point from the point
// store, the difference, square and sum stages, COORD_BITS + 1 steps of the
// digit-by-digit square root, and the state that shows the result. Each new
// row adds a read of the first point. Busy is high from the closing word
// until the last result has gone. The receiver cannot stall: each result is on
// the ports for exactly the one cycle in which done is high. Reset empties the
// set and clears the overflow mark; the contents of the point store are not
// cleared.
module pairwise_distance_matrix_3d #(
	parameter int MAX_POINTS = pdm_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = pdm_pkg::COORD_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic signed [pdm_pkg::COORD_PORT_W-1:0]   point_x,
	input  logic signed [pdm_pkg::COORD_PORT_W-1:0]   point_y,
	input  logic signed [pdm_pkg::COORD_PORT_W-1:0]   point_z,
	input  logic                                      last_point,
	output logic                                      done,
	output logic        [pdm_pkg::IDX_PORT_W-1:0]     row_index,
	output logic        [pdm_pkg::IDX_PORT_W-1:0]     col_index,
	output logic        [pdm_pkg::DIST_W-1:0]         distance,
	output logic                                      last_result,
	output logic                                      overflow
);

	localparam int IDX_PORT_W = pdm_pkg::IDX_PORT_W;
	localparam int DIST_W     = pdm_pkg::DIST_W;
	localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int PT_W       = 3 * COORD_BITS;
	localparam int SQ_W       = 2 * COORD_BITS;
	localparam int SUM_W      = SQ_W + 2;
	localparam int ROOT_W     = COORD_BITS + 1;
	localparam int REM_W      = ROOT_W + 1;
	localparam int TRY_W      = REM_W + 2;
	localparam int STEP_W     = $clog2(ROOT_W);

	pdm_pkg::state_t state_q, state_nx;

	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [IDX_W-1:0]  i_q, j_q;
	logic [STEP_W-1:0] step_q;

	logic [PT_W-1:0]   mem [MAX_POINTS];
	logic [PT_W-1:0]   rd_q;
	logic [PT_W-1:0]   row_q;
	logic [IDX_W-1:0]  rd_addr;
	logic              mem_we;
	logic              accept;
	logic              full;
	logic [IDX_W-1:0]  last_idx;
	logic              col_end, row_end;

	logic [COORD_BITS-1:0] dx_q, dy_q, dz_q;
	logic [SQ_W-1:0]       sx_q, sy_q, sz_q;
	logic [SUM_W-1:0]      rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [ROOT_W-1:0]     root_q;

	logic [TRY_W-1:0] rem_sh, trial, rem_sub;
	logic             take;

	assign accept   = start && (state_q == pdm_pkg::ST_IDLE);
	assign full     = (cnt_q >= CNT_W'(MAX_POINTS));
	assign last_idx = IDX_W'(cnt_q - CNT_W'(1));
	assign col_end  = (j_q == last_idx);
	assign row_end  = (i_q == last_idx);

	// Absolute difference of two signed coordinates; fits COORD_BITS unsigned bits.
	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
		if (d[COORD_BITS]) begin
			d = -d;
		end
		return d[COORD_BITS-1:0];
	endfunction

	// One step of the square root: bring down two radicand bits, try to subtract.
	always_comb begin
		rem_sh  = {rem_q, rad_q[SUM_W-1 -: 2]};
		trial   = TRY_W'({root_q, 2'b01});
		take    = (rem_sh >= trial);
		rem_sub = rem_sh - trial;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pdm_pkg::ST_IDLE: begin
				if (accept && last_point) begin
					state_nx = pdm_pkg::ST_RD_ROW;
				end
			end
			pdm_pkg::ST_RD_ROW:  state_nx = pdm_pkg::ST_ROW_CAP;
			pdm_pkg::ST_ROW_CAP: state_nx = pdm_pkg::ST_DIFF;
			pdm_pkg::ST_RD_COL:  state_nx = pdm_pkg::ST_DIFF;
			pdm_pkg::ST_DIFF:    state_nx = pdm_pkg::ST_SQR;
			pdm_pkg::ST_SQR:     state_nx = pdm_pkg::ST_SUM;
			pdm_pkg::ST_SUM:     state_nx = pdm_pkg::ST_ROOT;
			pdm_pkg::ST_ROOT: begin
				if (step_q == STEP_W'(ROOT_W - 1)) begin
					state_nx = pdm_pkg::ST_EMIT;
				end
			end
			pdm_pkg::ST_EMIT: begin
				if (col_end && row_end) begin
					state_nx = pdm_pkg::ST_IDLE;
				end else if (col_end) begin
					state_nx = pdm_pkg::ST_RD_ROW;
				end else begin
					state_nx = pdm_pkg::ST_RD_COL;
				end
			end
			default: state_nx = pdm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		done    = 1'b0;
		mem_we  = 1'b0;
		rd_addr = j_q;
		unique case (state_q)
			pdm_pkg::ST_IDLE: begin
				busy   = 1'b0;
				mem_we = accept && !full;
			end
			pdm_pkg::ST_RD_ROW: rd_addr = i_q;
			pdm_pkg::ST_EMIT:   done = 1'b1;
			default: ;
		endcase
	end

	assign row_index   = IDX_PORT_W'(i_q);
	assign col_index   = IDX_PORT_W'(j_q);
	assign distance    = DIST_W'(root_q);
	assign last_result = col_end && row_end;
	assign overflow    = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdm_pkg::ST_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				pdm_pkg::ST_IDLE: begin
					if (accept) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						i_q <= '0;
						j_q <= '0;
					end
				end
				pdm_pkg::ST_SUM: step_q <= '0;
				pdm_pkg::ST_ROOT: step_q <= step_q + STEP_W'(1);
				pdm_pkg::ST_EMIT: begin
					if (col_end && row_end) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						i_q   <= '0;
						j_q   <= '0;
					end else if (col_end) begin
						i_q <= i_q + IDX_W'(1);
						j_q <= '0;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Point store: one write port and one read port, read data registered.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[IDX_W-1:0]] <= {point_z[COORD_BITS-1:0], point_y[COORD_BITS-1:0],
				point_x[COORD_BITS-1:0]};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pdm_pkg::ST_ROW_CAP: row_q <= rd_q;
			pdm_pkg::ST_DIFF: begin
				dx_q <= abs_diff(row_q[COORD_BITS-1:0], rd_q[COORD_BITS-1:0]);
				dy_q <= abs_diff(row_q[2*COORD_BITS-1:COORD_BITS],
					rd_q[2*COORD_BITS-1:COORD_BITS]);
				dz_q <= abs_diff(row_q[PT_W-1:2*COORD_BITS], rd_q[PT_W-1:2*COORD_BITS]);
			end
			pdm_pkg::ST_SQR: begin
				sx_q <= SQ_W'(dx_q) * SQ_W'(dx_q);
				sy_q <= SQ_W'(dy_q) * SQ_W'(dy_q);
				sz_q <= SQ_W'(dz_q) * SQ_W'(dz_q);
			end
			pdm_pkg::ST_SUM: begin
				rad_q  <= SUM_W'(sx_q) + SUM_W'(sy_q) + SUM_W'(sz_q);
				rem_q  <= '0;
				root_q <= '0;
			end
			pdm_pkg::ST_ROOT: begin
				rad_q <= {rad_q[SUM_W-3:0], 2'b00};
				if (take) begin
					rem_q  <= REM_W'(rem_sub);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= REM_W'(rem_sh);
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

endmodule
